/* hw/rtl/conductor_fresnel_reflect_macros.svh */
// Assertion macros for the conductor Fresnel reflectance block.
// Used by the port checker; needs aclk and aresetn in scope.
`ifndef CONDUCTOR_FRESNEL_REFLECT_MACROS_SVH
`define CONDUCTOR_FRESNEL_REFLECT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define FCR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fcr assertion failed");

// Next-cycle implication
`define FCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fcr assertion failed");

`endif

/* hw/rtl/fcr_pkg.sv */
// Types and constants for the conductor Fresnel reflectance pipeline.
// No dependencies; imported by every module of the block.
package fcr_pkg;

    localparam int C_W      = 15;  // positive cosine magnitude
    localparam int WIDE_W   = 47;  // ratio numerators and denominators
    localparam int RATIO_W  = 16;  // Q0.16 ratio
    localparam int WEIGHT_W = 24;  // Q8.16 weight
    localparam int PROD_W   = 33;  // gain * (r_perp + r_par)

    localparam logic [45:0]         ONE_Q32    = 46'h0_0001_0000_0000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 24'hFF_FFFF;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [21:0]        eta;
        logic [21:0]        kappa;
        logic [15:0]        reflect_gain;
    } in_req_t;

    typedef struct packed {
        logic signed [15:0]  out_x;
        logic signed [15:0]  out_y;
        logic signed [15:0]  out_z;
        logic [WEIGHT_W-1:0] weight;
        logic                invalid;
    } out_req_t;

    // Per-item data that rides along with the arithmetic
    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic               invalid;
        logic [15:0]        gain;
        logic [C_W-1:0]     c;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic [WIDE_W-1:0] num_o;
        logic [WIDE_W-1:0] den_o;
        logic [WIDE_W-1:0] num_p;
        logic [WIDE_W-1:0] den_p;
    } front_t;

    typedef struct packed {
        side_t              side;
        logic [RATIO_W-1:0] r_o;
        logic [RATIO_W-1:0] r_p;
    } ratio_t;

endpackage

/* hw/rtl/fcr_front.sv */
// Front end: clamps, squares and products, a*cos^2, ratio operands.
// Seven register stages; depends on fcr_pkg.
module fcr_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  logic            in_valid,
    input  fcr_pkg::in_req_t in_req,
    output logic            out_valid,
    output fcr_pkg::front_t out_data
);
    import fcr_pkg::*;

    function automatic logic signed [15:0] neg_sat16(logic signed [15:0] v);
        logic signed [15:0] r;
        r = (v == 16'sh8000) ? 16'sh7FFF : -v;
        return r;
    endfunction

    logic [6:0] v_reg;

    logic [C_W-1:0] c_in;
    logic [21:0]    eta_c, kap_c;
    side_t          side_in;

    side_t       side1_reg, side2_reg, side3_reg, side4_reg, side5_reg, side6_reg;
    logic [43:0] eta2_reg, kap2_reg;
    logic [31:0] cos2_reg;
    logic [38:0] b1_reg, b2_reg, b3_reg, b4_reg, b5_reg, b6_reg;
    logic [44:0] a2_reg;
    logic [45:0] ao2_reg, ao3_reg, ao4_reg, ao5_reg, ao6_reg;
    logic [37:0] pl3_reg, ql5_reg;
    logic [36:0] ph3_reg, qh5_reg;
    logic [44:0] t4_reg;
    logic [45:0] ap6_reg;
    front_t      out_reg;

    logic [59:0] ac, tc;

    // input clamp and side data
    always_comb begin
        c_in  = (in_req.dir_z > 16'sd0) ? in_req.dir_z[C_W-1:0] : C_W'(1);
        eta_c = (in_req.eta == 22'd0) ? 22'd1 : in_req.eta;
        kap_c = (in_req.kappa == 22'd0) ? 22'd1 : in_req.kappa;
        side_in.out_x   = neg_sat16(in_req.dir_x);
        side_in.out_y   = neg_sat16(in_req.dir_y);
        side_in.out_z   = in_req.dir_z;
        side_in.invalid = (in_req.dir_z <= 16'sd0);
        side_in.gain    = in_req.reflect_gain;
        side_in.c       = c_in;
        ac = (60'(ph3_reg) << 23) + 60'(pl3_reg);
        tc = (60'(qh5_reg) << 23) + 60'(ql5_reg);
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (ce) begin
            // S1: squares and b = 4 c eta
            side1_reg <= side_in;
            eta2_reg  <= 44'(eta_c) * 44'(eta_c);
            kap2_reg  <= 44'(kap_c) * 44'(kap_c);
            cos2_reg  <= (32'(c_in) * 32'(c_in)) << 2;
            b1_reg    <= (39'(c_in) * 39'(eta_c)) << 2;
            // S2: a and a + cos^2
            side2_reg <= side1_reg;
            a2_reg    <= 45'(eta2_reg) + 45'(kap2_reg);
            ao2_reg   <= 46'(eta2_reg) + 46'(kap2_reg) + 46'(cos2_reg);
            b2_reg    <= b1_reg;
            // S3: a * c in two partial products
            side3_reg <= side2_reg;
            pl3_reg   <= 38'(a2_reg[22:0]) * 38'(side2_reg.c);
            ph3_reg   <= 37'(a2_reg[44:23]) * 37'(side2_reg.c);
            ao3_reg   <= ao2_reg;
            b3_reg    <= b2_reg;
            // S4: (a c) >> 15
            side4_reg <= side3_reg;
            t4_reg    <= ac[59:15];
            ao4_reg   <= ao3_reg;
            b4_reg    <= b3_reg;
            // S5: t * c in two partial products
            side5_reg <= side4_reg;
            ql5_reg   <= 38'(t4_reg[22:0]) * 38'(side4_reg.c);
            qh5_reg   <= 37'(t4_reg[44:23]) * 37'(side4_reg.c);
            ao5_reg   <= ao4_reg;
            b5_reg    <= b4_reg;
            // S6: a cos^2 + 1
            side6_reg <= side5_reg;
            ap6_reg   <= 46'(tc[59:15]) + ONE_Q32;
            ao6_reg   <= ao5_reg;
            b6_reg    <= b5_reg;
            // S7: numerators clamp at zero, denominators
            out_reg.side  <= side6_reg;
            out_reg.num_o <= (ao6_reg > 46'(b6_reg)) ? WIDE_W'(ao6_reg - 46'(b6_reg)) : '0;
            out_reg.den_o <= WIDE_W'(ao6_reg) + WIDE_W'(b6_reg);
            out_reg.num_p <= (ap6_reg > 46'(b6_reg)) ? WIDE_W'(ap6_reg - 46'(b6_reg)) : '0;
            out_reg.den_p <= WIDE_W'(ap6_reg) + WIDE_W'(b6_reg);
        end
    end

    assign out_valid = v_reg[6];
    assign out_data  = out_reg;

endmodule

/* hw/rtl/fcr_rdiv.sv */
// Two-lane restoring divider for the perpendicular and parallel ratios.
// One quotient bit per stage, RATIO_W stages; depends on fcr_pkg.
module fcr_rdiv (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  logic            in_valid,
    input  fcr_pkg::front_t in_data,
    output logic            out_valid,
    output fcr_pkg::ratio_t out_data
);
    import fcr_pkg::*;

    localparam int N = RATIO_W;

    logic              v_reg   [N];
    side_t             side_reg[N];
    logic [WIDE_W-1:0] rem_o_reg[N], den_o_reg[N], rem_p_reg[N], den_p_reg[N];
    logic [N-1:0]      q_o_reg[N], q_p_reg[N];

    logic              v_in   [N];
    side_t             side_in[N];
    logic [WIDE_W-1:0] rem_o_in[N], den_o_in[N], rem_p_in[N], den_p_in[N];
    logic [N-1:0]      q_o_in[N], q_p_in[N];

    logic [WIDE_W:0]   sh_o[N], sh_p[N];
    logic              ge_o[N], ge_p[N];

    // stage inputs and the compare-subtract of each stage
    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                v_in[k]     = in_valid;
                side_in[k]  = in_data.side;
                rem_o_in[k] = in_data.num_o;
                den_o_in[k] = in_data.den_o;
                rem_p_in[k] = in_data.num_p;
                den_p_in[k] = in_data.den_p;
                q_o_in[k]   = '0;
                q_p_in[k]   = '0;
            end else begin
                v_in[k]     = v_reg[k-1];
                side_in[k]  = side_reg[k-1];
                rem_o_in[k] = rem_o_reg[k-1];
                den_o_in[k] = den_o_reg[k-1];
                rem_p_in[k] = rem_p_reg[k-1];
                den_p_in[k] = den_p_reg[k-1];
                q_o_in[k]   = q_o_reg[k-1];
                q_p_in[k]   = q_p_reg[k-1];
            end
            sh_o[k] = {rem_o_in[k], 1'b0};
            sh_p[k] = {rem_p_in[k], 1'b0};
            ge_o[k] = (sh_o[k] >= {1'b0, den_o_in[k]});
            ge_p[k] = (sh_p[k] >= {1'b0, den_p_in[k]});
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (ce) begin
            for (int k = 0; k < N; k++) begin
                v_reg[k] <= v_in[k];
            end
        end
    end

    // remainder and quotient stages
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < N; k++) begin
                side_reg[k]  <= side_in[k];
                den_o_reg[k] <= den_o_in[k];
                den_p_reg[k] <= den_p_in[k];
                rem_o_reg[k] <= ge_o[k] ? WIDE_W'(sh_o[k] - {1'b0, den_o_in[k]})
                                        : WIDE_W'(sh_o[k]);
                rem_p_reg[k] <= ge_p[k] ? WIDE_W'(sh_p[k] - {1'b0, den_p_in[k]})
                                        : WIDE_W'(sh_p[k]);
                q_o_reg[k]   <= {q_o_in[k][N-2:0], ge_o[k]};
                q_p_reg[k]   <= {q_p_in[k][N-2:0], ge_p[k]};
            end
        end
    end

    assign out_valid     = v_reg[N-1];
    assign out_data.side = side_reg[N-1];
    assign out_data.r_o  = q_o_reg[N-1];
    assign out_data.r_p  = q_p_reg[N-1];

endmodule

/* hw/rtl/fcr_wdiv.sv */
// Weight: gain * (r_perp + r_par) divided by the cosine, saturated.
// One product stage, then WEIGHT_W restoring stages; depends on fcr_pkg.
module fcr_wdiv (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  fcr_pkg::ratio_t   in_data,
    output logic              out_valid,
    output fcr_pkg::out_req_t out_req
);
    import fcr_pkg::*;

    localparam int N = WEIGHT_W;

    logic              vp_reg;
    side_t             sidep_reg;
    logic [PROD_W-1:0] prod_reg;

    logic                v_reg   [N];
    side_t               side_reg[N];
    logic [C_W-1:0]      rem_reg [N];
    logic [N-1:0]        lo_reg  [N];
    logic [N-1:0]        q_reg   [N];
    logic                sat_reg [N];

    logic                v_in   [N];
    side_t               side_in[N];
    logic [C_W-1:0]      rem_in [N];
    logic [N-1:0]        lo_in  [N];
    logic [N-1:0]        q_in   [N];
    logic                sat_in [N];
    logic [C_W:0]        sh     [N];
    logic                ge     [N];

    // stage inputs; the first stage checks whether the quotient fits
    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                v_in[k]    = vp_reg;
                side_in[k] = sidep_reg;
                rem_in[k]  = C_W'(prod_reg[PROD_W-1:N]);
                lo_in[k]   = prod_reg[N-1:0];
                q_in[k]    = '0;
                sat_in[k]  = (C_W'(prod_reg[PROD_W-1:N]) >= sidep_reg.c);
            end else begin
                v_in[k]    = v_reg[k-1];
                side_in[k] = side_reg[k-1];
                rem_in[k]  = rem_reg[k-1];
                lo_in[k]   = lo_reg[k-1];
                q_in[k]    = q_reg[k-1];
                sat_in[k]  = sat_reg[k-1];
            end
            sh[k] = {rem_in[k], lo_in[k][N-1]};
            ge[k] = (sh[k] >= {1'b0, side_in[k].c});
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
            for (int k = 0; k < N; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (ce) begin
            vp_reg <= in_valid;
            for (int k = 0; k < N; k++) begin
                v_reg[k] <= v_in[k];
            end
        end
    end

    // product stage and long division stages
    always_ff @(posedge aclk) begin
        if (ce) begin
            sidep_reg <= in_data.side;
            prod_reg  <= PROD_W'(in_data.side.gain)
                       * (PROD_W'(in_data.r_o) + PROD_W'(in_data.r_p));
            for (int k = 0; k < N; k++) begin
                side_reg[k] <= side_in[k];
                sat_reg[k]  <= sat_in[k];
                rem_reg[k]  <= ge[k] ? C_W'(sh[k] - {1'b0, side_in[k].c}) : C_W'(sh[k]);
                lo_reg[k]   <= {lo_in[k][N-2:0], 1'b0};
                q_reg[k]    <= {q_in[k][N-2:0], ge[k]};
            end
        end
    end

    // result select
    always_comb begin
        out_req.out_x   = side_reg[N-1].out_x;
        out_req.out_y   = side_reg[N-1].out_y;
        out_req.out_z   = side_reg[N-1].out_z;
        out_req.invalid = side_reg[N-1].invalid;
        if (side_reg[N-1].invalid) begin
            out_req.weight = '0;
        end else if (sat_reg[N-1]) begin
            out_req.weight = WEIGHT_MAX;
        end else begin
            out_req.weight = q_reg[N-1];
        end
    end

    assign out_valid = v_reg[N-1];

endmodule

/* hw/rtl/conductor_fresnel_reflect.sv */
// Approximate conductor Fresnel reflectance, fully pipelined.
// It has 7 front stages, 16 ratio divider stages, 1 product
// stage and 24 weight divider stages. Throughput one request per cycle while the output is not stalled.
// The whole pipeline advances when the output slot is empty or taken.
// aresetn (synchronous, active low) clears all valid bits; data is not reset.
module conductor_fresnel_reflect (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fcr_pkg::in_req_t  s_req,
    output logic              m_valid,
    input  logic              m_ready,
    output fcr_pkg::out_req_t m_req
);
    import fcr_pkg::*;

    logic   ce;
    logic   front_valid, ratio_valid;
    front_t front_data;
    ratio_t ratio_data;

    // global advance
    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    fcr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (s_valid),
        .in_req   (s_req),
        .out_valid(front_valid),
        .out_data (front_data)
    );

    fcr_rdiv u_rdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (front_valid),
        .in_data  (front_data),
        .out_valid(ratio_valid),
        .out_data (ratio_data)
    );

    fcr_wdiv u_wdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (ratio_valid),
        .in_data  (ratio_data),
        .out_valid(m_valid),
        .out_req  (m_req)
    );

endmodule

/* hw/rtl/fcr_checker.sv */
// Port-level checker for conductor_fresnel_reflect, bound to the top level.
// Depends on fcr_pkg and conductor_fresnel_reflect_macros.svh.
`include "conductor_fresnel_reflect_macros.svh"

module fcr_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input fcr_pkg::in_req_t  s_req,
    input logic              m_valid,
    input logic              m_ready,
    input fcr_pkg::out_req_t m_req
);
    import fcr_pkg::*;

    // a stalled result holds
    `FCR_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_req))
    // an empty output slot never blocks the input
    `FCR_ASSERT_NOW(a_ready, !m_valid, s_ready)
    // invalid flag matches the cosine sign and zeroes the weight
    `FCR_ASSERT_NOW(a_inv, m_valid, m_req.invalid == (m_req.out_z[15] || m_req.out_z == 16'sd0))
    `FCR_ASSERT_NOW(a_wzero, m_valid && m_req.invalid, m_req.weight == '0)
    // negation saturates
    `FCR_ASSERT_NOW(a_negsat, m_valid, m_req.out_x != 16'sh8000 && m_req.out_y != 16'sh8000)

endmodule

bind conductor_fresnel_reflect fcr_checker u_fcr_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_req  (s_req),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_req  (m_req)
);

/* bench/fresnel_checker.sv */
// Checker for the conductor Fresnel reflectance block: predicts each result
// from the accepted requests and compares field by field. Depends on fcr_pkg.
`timescale 1ns / 1ps
module fresnel_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  fcr_pkg::in_req_t  s_req,
    input  logic              m_valid,
    input  logic              m_ready,
    input  fcr_pkg::out_req_t m_req,
    output int                fail_count,
    output int                pending,
    output int                seen_count
);
    import fcr_pkg::*;

    out_req_t reflect_q[$];

    // Mirror negation, saturating the most negative code
    function automatic logic signed [15:0] mirror(input logic signed [15:0] v);
        if (v == 16'sh8000) return 16'sd32767;
        return -v;
    endfunction

    function automatic out_req_t predict_reflect(input in_req_t r);
        out_req_t o;
        logic [63:0] eta, kap, c, a, cos2, b, a_o, a_p, n_o, n_p, r_o, r_p, w;
        o.out_x = mirror(r.dir_x);
        o.out_y = mirror(r.dir_y);
        o.out_z = r.dir_z;
        o.weight = '0;
        o.invalid = 1'b0;
        eta = (r.eta == 0) ? 64'd1 : 64'(r.eta);
        kap = (r.kappa == 0) ? 64'd1 : 64'(r.kappa);
        if (r.dir_z <= 0) begin
            o.invalid = 1'b1;
        end else begin
            c    = 64'(r.dir_z);
            a    = eta * eta + kap * kap;
            cos2 = c * c * 4;
            b    = c * eta * 4;
            a_o  = a + cos2;
            a_p  = ((((a * c) >> 15) * c) >> 15) + (64'd1 << 32);
            n_o  = (a_o > b) ? a_o - b : 64'd0;
            n_p  = (a_p > b) ? a_p - b : 64'd0;
            r_o  = (n_o << 16) / (a_o + b);
            r_p  = (n_p << 16) / (a_p + b);
            w    = (64'(r.reflect_gain) * (r_o + r_p)) / c;
            o.weight = (w > 64'hFF_FFFF) ? 24'hFF_FFFF : w[23:0];
        end
        return o;
    endfunction

    // Predict on request acceptance, compare on result acceptance
    always @(posedge aclk) begin
        out_req_t e;
        if (!aresetn) begin
            fail_count <= 0;
            seen_count <= 0;
            pending    <= 0;
        end else begin
            if (s_valid && s_ready) reflect_q.push_back(predict_reflect(s_req));
            if (m_valid && m_ready) begin
                seen_count <= seen_count + 1;
                if (reflect_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_req);
                    fail_count <= fail_count + 1;
                end else begin
                    e = reflect_q.pop_front();
                    if (e !== m_req) begin
                        $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%h inv=%b",
                                 $time, e.out_x, e.out_y, e.out_z, e.weight, e.invalid);
                        $display("%0t:          actual   x=%0d y=%0d z=%0d w=%h inv=%b",
                                 $time, m_req.out_x, m_req.out_y, m_req.out_z,
                                 m_req.weight, m_req.invalid);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= reflect_q.size();
        end
    end
endmodule

/* bench/tb.sv */
// Top of the Fresnel reflectance testbench: clock, reset, stimulus, verdict.
// Depends on fcr_pkg, conductor_fresnel_reflect and fresnel_checker.
`timescale 1ns / 1ps
module tb;
    import fcr_pkg::*;

    localparam int N_RANDOM  = 1830;
    localparam int LATENCY   = 48;
    localparam int MAX_CYCLE = 400000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    in_req_t  s_req = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    out_req_t m_req;
    int       fail_count, pending, seen_count;
    int       cycle = 0;
    bit       drain_on = 1'b0;

    always #1 aclk = ~aclk;

    conductor_fresnel_reflect u_dut (.*);
    fresnel_checker u_chk (.*);

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one request, hold until accepted, then maybe leave a gap
    task automatic send_req(input in_req_t r, input bit gaps);
        int g;
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
    endtask

    function automatic in_req_t dir_req(input int x, input int y, input int z,
                                        input int e, input int k, input int g);
        in_req_t r;
        r.dir_x = 16'(x); r.dir_y = 16'(y); r.dir_z = 16'(z);
        r.eta = 22'(e); r.kappa = 22'(k); r.reflect_gain = 16'(g);
        return r;
    endfunction

    // Mostly physically plausible bands, sometimes raw full-range fields
    function automatic in_req_t rand_req();
        in_req_t r;
        r = dir_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 3) != 0) begin
            r.dir_z = 16'($urandom_range(1, 32767));
            r.eta   = 22'($urandom_range(1 << 14, 6 << 16));
            r.kappa = 22'($urandom_range(0, 8 << 16));
            r.reflect_gain = 16'($urandom_range(0, 1 << 14));
            if ($urandom_range(0, 9) == 0) r.dir_z = 16'($urandom_range(1, 64));
        end
        return r;
    endfunction

    // Result side stalls: off while draining, random otherwise
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (drain_on || $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b1;
            end else begin
                g = pick_gap();
                m_ready <= (g == 0);
                if (g > 0) repeat (g - 1) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle >= MAX_CYCLE) begin
            $display("Timeout after %0d cycles", cycle);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int n_dir;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // Directed: field extremes, grazing and invalid cosines, zero eta/kappa
        send_req(dir_req(-32768, -32768, 32767, 0, 0, 65535), 0);
        send_req(dir_req(32767, 32767, 1, 4194303, 4194303, 65535), 0);
        send_req(dir_req(0, 0, 0, 65536, 0, 16384), 0);
        send_req(dir_req(100, -100, -32768, 65536, 65536, 16384), 0);
        send_req(dir_req(-1, 1, -1, 0, 4194303, 0), 1);
        send_req(dir_req(0, 0, 32767, 65536, 0, 16384), 1);
        send_req(dir_req(0, 0, 1, 0, 0, 65535), 1);
        send_req(dir_req(0, 0, 2, 1, 1, 65535), 0);
        send_req(dir_req(12000, 5000, 23170, 1 << 20, 1 << 16, 16384), 0);
        send_req(dir_req(0, 0, 16384, 4194303, 0, 65535), 1);
        send_req(dir_req(0, 0, 16384, 0, 4194303, 65535), 0);
        send_req(dir_req(0, 0, 32767, 2 << 16, 3 << 16, 16384), 0);
        send_req(dir_req(0, 0, 200, 1 << 16, 1, 65535), 0);
        n_dir = 13;
        for (int i = 0; i < N_RANDOM; i++) send_req(rand_req(), (i % 400) < 300);
        s_valid <= 1'b0;
        drain_on = 1'b1;
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        $display("Ran %0d requests (%0d directed), %0d results checked",
                 n_dir + N_RANDOM, n_dir, seen_count);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
